// ===== src/kpc_pkg.sv =====
// Package for the keyboard port controller: action and register codes, protocol bytes,
// and the structs that pass between the submodules.
// It depends on nothing else.
package kpc_pkg;

  typedef enum logic [2:0] {
    ACT_WRITE    = 3'd0,
    ACT_READ     = 3'd1,
    ACT_TICK     = 3'd2,
    ACT_KEY_DOWN = 3'd3,
    ACT_KEY_UP   = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    REG_DATA    = 2'd0,
    REG_STATUS  = 2'd1,
    REG_INTMASK = 2'd2,
    REG_UNUSED  = 2'd3
  } reg_sel_e;

  localparam logic [7:0] PREFIX_DOWN = 8'hA0;
  localparam logic [7:0] PREFIX_UP   = 8'hB0;
  localparam logic [7:0] KEY_CTRL    = 8'h11;
  localparam logic [7:0] KEY_SHIFT   = 8'h10;

  localparam int unsigned OBUF_DEPTH = 4;
  localparam int unsigned OBUF_PW    = 2;
  localparam int unsigned OBUF_CW    = 3;

  typedef struct packed {
    logic       push_first;
    logic       push_second;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       pop;
  } fifo_req_t;

  typedef struct packed {
    logic       en;
    logic       val;
    logic [7:0] key;
  } km_wr_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic       irq_level;
  } result_t;

endpackage

// ===== src/keyboard_port_controller.sv =====
// Top level of the keyboard port controller: input stage, register logic and submodules.
// It depends on kpc_pkg, kpc_keymap, kpc_byte_fifo and kpc_out_buf.
//
// Usage: every transaction on the input channel (in_valid_i, in_stall_o) carries one bus
// access, frame tick or key event, and produces exactly one result transaction on the
// output channel (out_valid_o, out_stall_i) with the register read data and the level of
// the interrupt line after the event. Results leave in the order the events came in.
// A transaction is registered into the update stage with the synchronous reads of the key
// map and the byte queue, then its result is registered into the result queue and offered.
// Throughput is one transaction per cycle while the input channel is not stalled. The key
// map and the byte queue are read at acceptance and written back in the update stage; a
// key map write is forwarded to the following event, and the queue memory is write-first,
// so back-to-back events on the same key or a tick right after a push see fresh data.
// The byte queue has two banks, so both bytes of a key message are stored in the same cycle.
// Reset clears all control state and marks every key as released through per-key valid
// bits, so no clearing pass is needed and events are taken from the first cycle.
// When the receiver stalls, results collect in a four-entry queue; the input channel
// stalls when the results held in that queue plus the transaction in the update stage
// reach the queue depth, so a stall on the output reaches the input only as it fills.
module keyboard_port_controller import kpc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned KEY_CODES   = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] action_i,
  input  logic [1:0] reg_select_i,
  input  logic [7:0] write_value_i,
  input  logic [7:0] key_index_i,
  input  logic [7:0] scan_code_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_value_o,
  output logic       irq_level_o
);

  // Update stage registers: the accepted transaction, aligned with the memory read data.
  logic       s1_valid_q;
  logic [2:0] s1_action_q;
  logic [1:0] s1_sel_q;
  logic [7:0] s1_wval_q;
  logic [7:0] s1_key_q;
  logic [7:0] s1_scan_q;

  // Architectural registers of the port.
  logic [7:0] data_byte_q, data_byte_d;
  logic       data_ready_q, data_ready_d;
  logic       int_pending_q, int_pending_d;
  logic       int_enable_q, int_enable_d;
  // Shadow copies of the CTRL and SHIFT entries of the key map, used for the prefix byte.
  logic       ctrl_q, ctrl_d;
  logic       shift_q, shift_d;

  logic               in_accept;
  logic               key_ok;
  logic               pressed;
  logic               ctrl_held, shift_held;
  logic               data_read;
  logic [7:0]         rd_val;
  logic               fifo_not_empty;
  logic [7:0]         fifo_head;
  fifo_req_t          fifo_req;
  km_wr_t             km_wr;
  result_t            result;
  result_t            out_data;
  logic [OBUF_CW-1:0] obuf_count;
  logic [OBUF_CW:0]   obuf_load;

  // The result queue must be able to hold everything in flight plus one more transaction.
  assign obuf_load  = {1'b0, obuf_count} + (OBUF_CW+1)'(s1_valid_q);
  assign in_stall_o = (obuf_load >= (OBUF_CW+1)'(OBUF_DEPTH));
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_action_q <= action_i;
      s1_sel_q    <= reg_select_i;
      s1_wval_q   <= write_value_i;
      s1_key_q    <= key_index_i;
      s1_scan_q   <= scan_code_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      data_byte_q   <= '0;
      data_ready_q  <= 1'b0;
      int_pending_q <= 1'b0;
      int_enable_q  <= 1'b0;
      ctrl_q        <= 1'b0;
      shift_q       <= 1'b0;
    end else begin
      s1_valid_q    <= in_accept;
      data_byte_q   <= data_byte_d;
      data_ready_q  <= data_ready_d;
      int_pending_q <= int_pending_d;
      int_enable_q  <= int_enable_d;
      ctrl_q        <= ctrl_d;
      shift_q       <= shift_d;
    end
  end

  kpc_keymap #(
    .KEY_CODES(KEY_CODES)
  ) u_keymap (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_key_i (key_index_i),
    .wr_i     (km_wr),
    .pressed_o(pressed)
  );

  kpc_byte_fifo #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_byte_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (fifo_req),
    .not_empty_o(fifo_not_empty),
    .head_o     (fifo_head)
  );

  // Key codes at or above the map size are ignored entirely.
  assign key_ok     = ({1'b0, s1_key_q} < 9'(KEY_CODES));
  // A key-down of CTRL or SHIFT itself already counts as held for its own prefix.
  assign ctrl_held  = ctrl_q || (s1_key_q == KEY_CTRL);
  assign shift_held = shift_q || (s1_key_q == KEY_SHIFT);
  assign data_read  = s1_valid_q && (action_e'(s1_action_q) == ACT_READ)
                      && (reg_sel_e'(s1_sel_q) == REG_DATA);

  always_comb begin
    data_byte_d   = data_byte_q;
    data_ready_d  = data_ready_q;
    int_pending_d = int_pending_q;
    int_enable_d  = int_enable_q;
    ctrl_d        = ctrl_q;
    shift_d       = shift_q;
    rd_val        = '0;
    fifo_req      = '0;
    km_wr.en      = 1'b0;
    km_wr.val     = 1'b0;
    km_wr.key     = s1_key_q;
    if (s1_valid_q) begin
      case (action_e'(s1_action_q))
        ACT_WRITE: begin
          // Writes to the data, status and unused registers have no effect; only the mask register is writable.
          if (reg_sel_e'(s1_sel_q) == REG_INTMASK) begin
            int_enable_d = s1_wval_q[0];
          end
        end
        ACT_READ: begin
          case (reg_sel_e'(s1_sel_q))
            REG_DATA: begin
              // Reading data acknowledges it, even when nothing was ready.
              rd_val        = data_byte_q;
              data_ready_d  = 1'b0;
              int_pending_d = 1'b0;
            end
            REG_STATUS:  rd_val = {7'd0, data_ready_q};
            REG_INTMASK: rd_val = {7'd0, int_pending_q};
            default:     rd_val = '0;
          endcase
        end
        ACT_TICK: begin
          if (!data_ready_q && fifo_not_empty) begin
            data_ready_d  = 1'b1;
            data_byte_d   = fifo_head;
            fifo_req.pop  = 1'b1;
          end
          if (data_ready_d && int_enable_q && !int_pending_q) begin
            int_pending_d = 1'b1;
          end
        end
        ACT_KEY_DOWN: begin
          if (key_ok && !pressed) begin
            km_wr.en  = 1'b1;
            km_wr.val = 1'b1;
            if (s1_key_q == KEY_CTRL) begin
              ctrl_d = 1'b1;
            end
            if (s1_key_q == KEY_SHIFT) begin
              shift_d = 1'b1;
            end
            // An untranslated key updates the map but sends no message.
            if (s1_scan_q != '0) begin
              fifo_req.push_first  = 1'b1;
              fifo_req.push_second = 1'b1;
              fifo_req.first_byte  = PREFIX_DOWN | {4'd0, ctrl_held, shift_held, 2'd0};
              fifo_req.second_byte = s1_scan_q;
            end
          end
        end
        ACT_KEY_UP: begin
          if (key_ok && pressed) begin
            km_wr.en  = 1'b1;
            km_wr.val = 1'b0;
            if (s1_key_q == KEY_CTRL) begin
              ctrl_d = 1'b0;
            end
            if (s1_key_q == KEY_SHIFT) begin
              shift_d = 1'b0;
            end
            if (s1_scan_q != '0) begin
              fifo_req.push_first  = 1'b1;
              fifo_req.push_second = 1'b1;
              fifo_req.first_byte  = PREFIX_UP;
              fifo_req.second_byte = s1_scan_q;
            end
          end
        end
        default: begin
          rd_val = '0;
        end
      endcase
    end
  end

  assign result.read_value = rd_val;
  assign result.irq_level  = int_pending_d;

  kpc_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (s1_valid_q),
    .data_i     (result),
    .count_o    (obuf_count),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .data_o     (out_data)
  );

  assign read_value_o = out_data.read_value;
  assign irq_level_o  = out_data.irq_level;

  a_irq_needs_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(int_pending_q) |-> data_ready_q)
    else $error("interrupt raised without a ready byte");

  a_ready_cleared_by_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(data_ready_q) |-> $past(data_read))
    else $error("data ready dropped without a data read");

endmodule

// ===== src/kpc_keymap.sv =====
// Pressed-key map: a one-bit synchronous memory with per-entry valid bits and write forwarding.
// It depends on kpc_pkg.
module kpc_keymap import kpc_pkg::*; #(
  parameter int unsigned KEY_CODES = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] rd_key_i,
  input  km_wr_t     wr_i,
  output logic       pressed_o
);

  localparam int unsigned KW = $clog2(KEY_CODES);

  logic                 mem_q [KEY_CODES];
  logic [KEY_CODES-1:0] valid_q;
  logic                 rdata_q;
  logic [KW-1:0]        addr_q;
  logic                 last_we_q;
  logic                 last_val_q;
  logic [KW-1:0]        last_addr_q;
  logic [KW-1:0]        rd_addr;
  logic [KW-1:0]        wr_addr;

  assign rd_addr = rd_key_i[KW-1:0];
  assign wr_addr = wr_i.key[KW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_addr] <= wr_i.val;
    end
    rdata_q     <= mem_q[rd_addr];
    addr_q      <= rd_addr;
    last_val_q  <= wr_i.val;
    last_addr_q <= wr_addr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      last_we_q <= 1'b0;
    end else begin
      last_we_q <= wr_i.en;
      if (wr_i.en) begin
        valid_q[wr_addr] <= 1'b1;
      end
    end
  end

  // A write at the same edge as the read is not seen by the memory, so it is forwarded.
  assign pressed_o = (last_we_q && (last_addr_q == addr_q)) ? last_val_q
                                                            : (valid_q[addr_q] && rdata_q);

endmodule

// ===== src/kpc_byte_fifo.sv =====
// Byte FIFO in two synchronous memory banks, so that a prefix and scan code pair can be
// written in the same cycle. It depends on kpc_pkg.
module kpc_byte_fifo import kpc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  fifo_req_t req_i,
  output logic      not_empty_o,
  output logic [7:0] head_o
);

  localparam int unsigned HALF  = (QUEUE_DEPTH + 1) / 2;
  localparam int unsigned ROWS  = (HALF < 2) ? 2 : 2 ** $clog2(HALF);
  localparam int unsigned SLOTS = 2 * ROWS;
  localparam int unsigned PW    = $clog2(SLOTS);
  localparam int unsigned RW    = PW - 1;
  localparam int unsigned CW    = $clog2(QUEUE_DEPTH + 1);

  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, wr_ptr_nx;
  logic [CW-1:0] count_q, count_d;
  logic [CW:0]   count_plus;
  logic          push_first, push_second;
  logic [RW-1:0] rd_row;
  logic          bank_we [2];
  logic [RW-1:0] bank_wa [2];
  logic [7:0]    bank_wd [2];
  logic [7:0]    rdata_q [2];

  assign count_plus  = {1'b0, count_q} + (CW+1)'(1);
  assign push_first  = req_i.push_first && (count_q < CW'(QUEUE_DEPTH));
  assign push_second = req_i.push_second && (count_plus < (CW+1)'(QUEUE_DEPTH));
  assign wr_ptr_nx   = wr_ptr_q + PW'(1);
  assign wr_ptr_d    = wr_ptr_q + PW'(push_first) + PW'(push_second);
  assign rd_ptr_d    = rd_ptr_q + PW'(req_i.pop);
  assign count_d     = count_q + CW'(push_first) + CW'(push_second) - CW'(req_i.pop);
  assign rd_row      = rd_ptr_d[PW-1:1];

  for (genvar b = 0; b < 2; b++) begin : g_bank
    logic [7:0] mem [ROWS];
    logic       first_here;

    assign first_here = (wr_ptr_q[0] == 1'(b));
    assign bank_we[b] = (push_first && first_here) || (push_second && !first_here);
    assign bank_wd[b] = (push_first && first_here) ? req_i.first_byte : req_i.second_byte;
    assign bank_wa[b] = first_here ? wr_ptr_q[PW-1:1] : wr_ptr_nx[PW-1:1];

    // Write-first read, so a byte pushed into an empty queue is seen at the head at once.
    always_ff @(posedge clk_i) begin
      if (bank_we[b]) begin
        mem[bank_wa[b]] <= bank_wd[b];
      end
      if (bank_we[b] && (bank_wa[b] == rd_row)) begin
        rdata_q[b] <= bank_wd[b];
      end else begin
        rdata_q[b] <= mem[rd_row];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
    end
  end

  assign not_empty_o = (count_q != '0);
  assign head_o      = rdata_q[rd_ptr_q[0]];

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("byte queue count above its depth");

  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q - rd_ptr_q) == PW'(count_q))
    else $error("byte queue pointers disagree with count");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.pop |-> (count_q != '0))
    else $error("pop from an empty byte queue");

endmodule

// ===== src/kpc_out_buf.sv =====
// Result queue of a few entries that decouples the output channel from the update stage.
// It depends on kpc_pkg.
module kpc_out_buf import kpc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  result_t            data_i,
  output logic [OBUF_CW-1:0] count_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output result_t            data_o
);

  result_t              entry_q [OBUF_DEPTH];
  logic [OBUF_PW-1:0]   rd_ptr_q, wr_ptr_q;
  logic [OBUF_CW-1:0]   count_q;
  logic                 pop;

  assign pop = (count_q != '0) && !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_q + OBUF_PW'(pop);
      wr_ptr_q <= wr_ptr_q + OBUF_PW'(push_i);
      count_q  <= count_q + OBUF_CW'(push_i) - OBUF_CW'(pop);
    end
  end

  assign count_o     = count_q;
  assign out_valid_o = (count_q != '0);
  assign data_o      = entry_q[rd_ptr_q];

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop) |-> (count_q < OBUF_CW'(OBUF_DEPTH)))
    else $error("result queue overflow");

endmodule
